// File: hdl/mpq_pkg.sv
// mpq_pkg: shared widths, codes and types for the max priority queue
// no dependencies; used by mpq_cell, max_priority_queue_unique_id and tb
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int ID_W     = 31;
    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_slot;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic capture;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hdl/mpq_cell.sv
// mpq_cell: one slot of the sorted chain, holds one entry and its compare flags
// depends on mpq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell import mpq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [ID_W-1:0]  i_cmp_id,
    input  wire logic [KEY_W-1:0] i_cmp_key,
    input  wire t_slot            i_new,
    input  wire t_slot            i_prev,
    input  wire logic             i_prev_ge,
    input  wire t_slot            i_next,
    input  wire logic             i_del,
    output t_slot                 o_slot,
    output t_slot                 o_nxt,
    output logic                  o_match,
    output logic                  o_ge
);

    t_slot r_slot;
    t_slot n_slot;
    logic  r_match;
    logic  r_ge;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins) begin
            // keys >= new key stay, first smaller takes new entry, the rest shift down
            if (!r_ge) begin
                n_slot = i_prev_ge ? i_new : i_prev;
            end
        end else if (i_ctl.del) begin
            if (i_del) begin
                n_slot = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
            r_match      <= 1'b0;
            r_ge         <= 1'b0;
        end else begin
            r_slot <= n_slot;
            if (i_ctl.capture) begin
                r_match <= r_slot.valid && (r_slot.id == i_cmp_id);
                r_ge    <= r_slot.valid && (r_slot.key >= i_cmp_key);
            end
        end
    end

    assign o_slot  = r_slot;
    assign o_nxt   = n_slot;
    assign o_match = r_match;
    assign o_ge    = r_ge;

endmodule

`default_nettype wire

// File: hdl/max_priority_queue_unique_id.sv
// channel  | valid   | stall   | payload
// input    | i_valid | o_stall | i_mode, i_item_id, i_item_key
// output   | o_valid | i_stall | o_status, o_out_id, o_out_key, o_top_valid,
//          |         |         | o_top_id, o_top_key, o_entry_count
//
// each transaction has a compare step, which broadcasts the item and registers the
// per-cell id match and key compare, then an apply step, which shifts the chain of cells and loads the result
// the apply cycle waits while the output register holds a result that is stalled
// synchronous active-low reset empties the queue at once; no clearing pass
// depends on mpq_pkg and mpq_cell
`timescale 1ns / 1ps
`default_nettype none

module max_priority_queue_unique_id import mpq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic [ID_W-1:0]     i_item_id,
    input  wire logic [KEY_W-1:0]    i_item_key,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ID_W-1:0]          o_out_id,
    output logic [KEY_W-1:0]         o_out_key,
    output logic                     o_top_valid,
    output logic [ID_W-1:0]          o_top_id,
    output logic [KEY_W-1:0]         o_top_key,
    output logic [COUNT_W-1:0]       o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {S_IDLE, S_APPLY} t_state;

    t_state              r_state;
    logic [MODE_W-1:0]   r_mode;
    logic [ID_W-1:0]     r_item_id;
    logic [KEY_W-1:0]    r_item_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_out_id;
    logic [KEY_W-1:0]    r_out_key;
    logic                r_top_valid;
    logic [ID_W-1:0]     r_top_id;
    logic [KEY_W-1:0]    r_top_key;
    logic [CNT_W-1:0]    r_out_count;

    t_slot               w_slot [CAPACITY];
    t_slot               w_nxt  [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_del;
    logic [KEY_W-1:0]    w_sel_key;

    t_cell_ctl           w_ctl;
    t_slot               w_new;
    logic                w_accept;
    logic                w_load;
    logic                w_any_hit;
    logic                w_full;
    logic [STATUS_W-1:0] w_status;
    logic [ID_W-1:0]     w_out_id;
    logic [KEY_W-1:0]    w_out_key;
    logic                w_do_ins;
    logic                w_do_del;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_APPLY) && (!r_out_valid || !i_stall);

    // hit vector: slot 0 for extract, id match otherwise
    always_comb begin
        w_hit = w_match;
        if (r_mode == MODE_EXTRACT) begin
            w_hit    = '0;
            w_hit[0] = w_valid[0];
        end
    end

    // log-step prefix or: a slot at or behind the hit pulls from its successor
    always_comb begin
        w_del = w_hit;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            w_del = w_del | (w_del << s);
        end
    end

    always_comb begin
        w_sel_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel_key = w_sel_key | (w_match[i] ? w_slot[i].key : '0);
        end
    end

    assign w_any_hit = w_del[CAPACITY-1];
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_status  = ST_OK;
        w_out_id  = '0;
        w_out_key = '0;
        w_do_ins  = 1'b0;
        w_do_del  = 1'b0;
        unique case (r_mode)
            MODE_INSERT: begin
                if (w_any_hit) begin
                    w_status = ST_DUP;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            MODE_EXTRACT: begin
                if (!w_valid[0]) begin
                    w_status = ST_MISS;
                end else begin
                    w_do_del  = 1'b1;
                    w_out_id  = w_slot[0].id;
                    w_out_key = w_slot[0].key;
                end
            end
            MODE_REMOVE: begin
                if (!w_any_hit) begin
                    w_status = ST_MISS;
                end else begin
                    w_do_del  = 1'b1;
                    w_out_id  = r_item_id;
                    w_out_key = w_sel_key;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_ctl.capture = w_accept;
    assign w_ctl.ins     = w_load && w_do_ins;
    assign w_ctl.del     = w_load && w_do_del;

    assign w_new.valid = 1'b1;
    assign w_new.id    = r_item_id;
    assign w_new.key   = r_item_key;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot w_prev;
        t_slot w_next;
        logic  w_prev_ge;

        if (g == 0) begin : g_head
            assign w_prev    = '0;
            assign w_prev_ge = 1'b1;
        end else begin : g_body
            assign w_prev    = w_slot[g-1];
            assign w_prev_ge = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_slot[g+1];
        end

        mpq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_cmp_id  (i_item_id),
            .i_cmp_key (i_item_key),
            .i_new     (w_new),
            .i_prev    (w_prev),
            .i_prev_ge (w_prev_ge),
            .i_next    (w_next),
            .i_del     (w_del[g]),
            .o_slot    (w_slot[g]),
            .o_nxt     (w_nxt[g]),
            .o_match   (w_match[g]),
            .o_ge      (w_ge[g])
        );

        assign w_valid[g] = w_slot[g].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a load in the same cycle refills the output register instead
            if (r_out_valid && !i_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode     <= i_mode;
                        r_item_id  <= i_item_id;
                        r_item_key <= i_item_key;
                        r_state    <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_load) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_status    <= w_status;
                        r_out_id    <= w_out_id;
                        r_out_key   <= w_out_key;
                        r_top_valid <= w_nxt[0].valid;
                        r_top_id    <= w_nxt[0].valid ? w_nxt[0].id : '0;
                        r_top_key   <= w_nxt[0].valid ? w_nxt[0].key : '0;
                        r_out_count <= n_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, r_out_count};

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_out_id      = r_out_id;
    assign o_out_key     = r_out_key;
    assign o_top_valid   = r_top_valid;
    assign o_top_id      = r_top_id;
    assign o_top_key     = r_top_key;
    assign o_entry_count = w_count_ext[COUNT_W-1:0];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("valid cells disagree with entry count");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + CAPACITY'(1))) == '0)
        else $error("valid cells are not a contiguous head of the chain");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && (r_count == $past(r_count))))
        else $error("chain changed or input opened during compare cycle");

endmodule

`default_nettype wire

// File: sim/tb.sv
// tb: self-checking testbench for max_priority_queue_unique_id
// keeps its own sorted mirror of the queue and checks every result transaction
// depends on mpq_pkg and the max_priority_queue_unique_id rtl
`timescale 1ns / 1ps

module tb;
    import mpq_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;
    // unused mode code, the block does nothing but report
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;
    localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_id;
        logic [KEY_W-1:0]    out_key;
        logic                top_valid;
        logic [ID_W-1:0]     top_id;
        logic [KEY_W-1:0]    top_key;
        logic [COUNT_W-1:0]  entry_count;
    } t_queue_reply;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [MODE_W-1:0]   i_mode;
    logic [ID_W-1:0]     i_item_id;
    logic [KEY_W-1:0]    i_item_key;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_out_id;
    logic [KEY_W-1:0]    o_out_key;
    logic                o_top_valid;
    logic [ID_W-1:0]     o_top_id;
    logic [KEY_W-1:0]    o_top_key;
    logic [COUNT_W-1:0]  o_entry_count;

    // mirror of the queue contents, slot 0 holds the maximum
    logic [ID_W-1:0]  mirror_ids [CAPACITY];
    logic [KEY_W-1:0] mirror_keys[CAPACITY];
    int               mirror_count;

    t_queue_reply replies_due[$];

    int  error_count;
    int  replies_checked;
    int  mode_tally[4];
    int  status_tally[4];
    int  peak_count;
    bit  sender_gaps;
    bit  receiver_gaps;
    int  stall_hold_cycles;

    max_priority_queue_unique_id #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_item_id    (i_item_id),
        .i_item_key   (i_item_key),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_id     (o_out_id),
        .o_out_key    (o_out_key),
        .o_top_valid  (o_top_valid),
        .o_top_id     (o_top_id),
        .o_top_key    (o_top_key),
        .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // generous ceiling, many times the slowest legal run
    initial begin
        #(10_000_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int find_id(input logic [ID_W-1:0] id);
        int i;
        for (i = 0; i < mirror_count; i++) begin
            if (mirror_ids[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void take_out(input int pos);
        int i;
        for (i = pos; i + 1 < mirror_count; i++) begin
            mirror_ids[i]  = mirror_ids[i + 1];
            mirror_keys[i] = mirror_keys[i + 1];
        end
        mirror_count--;
    endfunction

    function automatic t_queue_reply predict_queue_op(input logic [MODE_W-1:0] mode,
            input logic [ID_W-1:0] id, input logic [KEY_W-1:0] key);
        t_queue_reply r;
        int hit;
        int pos;
        int i;
        r = '0;
        r.status = ST_OK;
        hit = find_id(id);
        case (mode)
            MODE_INSERT: begin
                if (hit >= 0) begin
                    r.status = ST_DUP;
                end else if (mirror_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // equal keys stay behind the ones already stored
                    pos = 0;
                    while (pos < mirror_count && mirror_keys[pos] >= key) pos++;
                    for (i = mirror_count; i > pos; i--) begin
                        mirror_ids[i]  = mirror_ids[i - 1];
                        mirror_keys[i] = mirror_keys[i - 1];
                    end
                    mirror_ids[pos]  = id;
                    mirror_keys[pos] = key;
                    mirror_count++;
                end
            end
            MODE_EXTRACT: begin
                if (mirror_count == 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.out_id  = mirror_ids[0];
                    r.out_key = mirror_keys[0];
                    take_out(0);
                end
            end
            MODE_REMOVE: begin
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.out_id  = mirror_ids[hit];
                    r.out_key = mirror_keys[hit];
                    take_out(hit);
                end
            end
            default: begin
            end
        endcase
        if (mirror_count > 0) begin
            r.top_valid = 1'b1;
            r.top_id    = mirror_ids[0];
            r.top_key   = mirror_keys[0];
        end
        r.entry_count = COUNT_W'(mirror_count);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
            input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // result side: stall pattern drawn per transaction, plus an optional long hold
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold_cycles > 0) begin
                stall_hold_cycles--;
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall) begin
                stall_left = receiver_gaps ? $urandom_range(0, 19) : 0;
                i_stall <= (stall_left != 0);
            end else begin
                if (stall_left > 0) stall_left--;
                i_stall <= (stall_left != 0);
            end
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_queue_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (replies_due.size() == 0) begin
                $error("result with nothing pending: status %0d id 0x%0h", o_status, o_out_id);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("status", KEY_W'(want.status), KEY_W'(o_status));
                check_field("out_id", KEY_W'(want.out_id), KEY_W'(o_out_id));
                check_field("out_key", want.out_key, o_out_key);
                check_field("top_valid", KEY_W'(want.top_valid), KEY_W'(o_top_valid));
                check_field("top_id", KEY_W'(want.top_id), KEY_W'(o_top_id));
                check_field("top_key", want.top_key, o_top_key);
                check_field("entry_count", KEY_W'(want.entry_count), KEY_W'(o_entry_count));
                replies_checked++;
            end
        end
    end

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic offer_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
            input logic [KEY_W-1:0] key);
        int gap;
        t_queue_reply r;
        gap = sender_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_item_id  <= id;
        i_item_key <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = predict_queue_op(mode, id, key);
        replies_due.insert(replies_due.size(), r);
        mode_tally[mode]++;
        status_tally[r.status]++;
        if (mirror_count > peak_count) peak_count = mirror_count;
    endtask

    task automatic wait_replies_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] draw_id();
        if ($urandom_range(0, 3) == 0) return ID_W'($urandom());
        return ID_W'($urandom_range(1, 48));
    endfunction

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        id = draw_id();
        while (find_id(id) >= 0) id = draw_id();
        return id;
    endfunction

    function automatic logic [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return KEY_MAX;
            2, 3, 4, 5: return KEY_W'($urandom_range(0, 7));  // plenty of ties
            default: return KEY_W'($urandom());
        endcase
    endfunction

    function automatic logic [ID_W-1:0] stored_id();
        return mirror_ids[$urandom_range(0, mirror_count - 1)];
    endfunction

    task automatic offer_random_op(input int insert_pct);
        int roll;
        logic [ID_W-1:0] id;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            offer_request(MODE_IDLE, draw_id(), draw_key());
        end else if ($urandom_range(0, 99) < insert_pct) begin
            if (mirror_count > 0 && $urandom_range(0, 9) == 0) id = stored_id();
            else id = fresh_id();
            offer_request(MODE_INSERT, id, draw_key());
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45) offer_request(MODE_EXTRACT, draw_id(), draw_key());
            else if (roll < 85 && mirror_count > 0) offer_request(MODE_REMOVE, stored_id(), draw_key());
            else offer_request(MODE_REMOVE, fresh_id(), draw_key());
        end
    endtask

    task automatic test_corner_cases();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        offer_request(MODE_EXTRACT, 31'd0, '0);            // empty store
        offer_request(MODE_REMOVE, 31'd1, '0);             // absent on empty
        offer_request(MODE_IDLE, ID_MAX, KEY_MAX);
        offer_request(MODE_INSERT, 31'd0, '0);             // id zero is storable
        offer_request(MODE_INSERT, ID_MAX, KEY_MAX);
        offer_request(MODE_INSERT, 31'd0, 32'd5);          // duplicate
        offer_request(MODE_INSERT, 31'd10, 32'd1000);
        offer_request(MODE_INSERT, 31'd11, 32'd1000);
        offer_request(MODE_INSERT, 31'd12, 32'd1000);
        offer_request(MODE_INSERT, 31'd13, 32'd2000);
        offer_request(MODE_REMOVE, 31'd11, '0);            // middle of a tie run
        offer_request(MODE_REMOVE, 31'd99, '0);
        offer_request(MODE_IDLE, 31'd13, 32'd7);
        offer_request(MODE_EXTRACT, '0, '0);
        offer_request(MODE_EXTRACT, '0, '0);
        offer_request(MODE_EXTRACT, '0, '0);               // earliest of the ties
        offer_request(MODE_INSERT, 31'd11, 32'd1000);      // reinsert goes behind id 12
        offer_request(MODE_EXTRACT, '0, '0);
        offer_request(MODE_REMOVE, 31'd0, '0);
        offer_request(MODE_EXTRACT, '0, '0);
        offer_request(MODE_EXTRACT, '0, '0);
        wait_replies_drained();
    endtask

    task automatic test_full_store();
        logic [ID_W-1:0] id;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        while (mirror_count > 0) offer_request(MODE_EXTRACT, '0, '0);
        while (mirror_count < CAPACITY) offer_request(MODE_INSERT, fresh_id(), draw_key());
        offer_request(MODE_INSERT, fresh_id(), draw_key());   // full
        offer_request(MODE_INSERT, stored_id(), draw_key());  // duplicate wins over full
        id = mirror_ids[CAPACITY / 2];
        offer_request(MODE_REMOVE, id, '0);
        offer_request(MODE_INSERT, fresh_id(), KEY_MAX);
        while (mirror_count > 0) offer_request(MODE_EXTRACT, draw_id(), draw_key());
        offer_request(MODE_EXTRACT, '0, '0);
        wait_replies_drained();
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 10; phase++) begin
            // first phase runs back to back on both sides
            sender_gaps   = (phase != 0) && ($urandom_range(0, 2) != 0);
            receiver_gaps = (phase != 0) && ($urandom_range(0, 2) != 0);
            for (n = 0; n < 128; n++) offer_random_op(phase[0] ? 35 : 75);
            if ($urandom_range(0, 1) == 0) wait_replies_drained();
        end
        wait_replies_drained();
    endtask

    task automatic test_output_backpressure();
        int n;
        sender_gaps       = 1'b0;
        receiver_gaps     = 1'b0;
        stall_hold_cycles = 200;
        for (n = 0; n < 40; n++) offer_random_op(60);
        wait_replies_drained();
    endtask

    initial begin
        int n;
        error_count       = 0;
        replies_checked   = 0;
        peak_count        = 0;
        mirror_count      = 0;
        stall_hold_cycles = 0;
        sender_gaps       = 1'b0;
        receiver_gaps     = 1'b0;
        for (n = 0; n < 4; n++) begin
            mode_tally[n]   = 0;
            status_tally[n] = 0;
        end
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_mode     <= MODE_INSERT;
        i_item_id  <= '0;
        i_item_key <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_full_store();
        test_output_backpressure();
        test_random_traffic();

        i_valid <= 1'b0;
        for (n = 0; n < 4000 && replies_due.size() != 0; n++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $error("%0d expected results never arrived", replies_due.size());
            error_count++;
        end

        $display("covered %0d transactions: %0d insert, %0d extract, %0d remove, %0d idle code",
                 replies_checked, mode_tally[MODE_INSERT], mode_tally[MODE_EXTRACT],
                 mode_tally[MODE_REMOVE], mode_tally[MODE_IDLE]);
        $display("refusals: %0d duplicate, %0d full, %0d empty or missing; peak fill %0d of %0d",
                 status_tally[ST_DUP], status_tally[ST_FULL], status_tally[ST_MISS],
                 peak_count, CAPACITY);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/mpq_pkg.sv
hdl/mpq_cell.sv
hdl/max_priority_queue_unique_id.sv
sim/tb.sv
